@@ rtl/core/ezvr_pkg.sv @@
package ezvr_pkg;

  localparam int Q = 30;
  localparam logic signed [33:0] Q30_ONE  = 34'sd1073741824;
  localparam logic signed [63:0] Q30_HALF = 64'sd536870912;

  localparam logic signed [33:0] S_C1  = 34'sd1686629713;
  localparam logic signed [33:0] S_C3  = 34'sd693598668;
  localparam logic signed [33:0] S_C5  = 34'sd85569306;
  localparam logic signed [33:0] S_C7  = 34'sd5026995;
  localparam logic signed [33:0] S_C9  = 34'sd172272;
  localparam logic signed [33:0] S_C11 = 34'sd3864;
  localparam logic signed [33:0] S_C13 = 34'sd61;

  // Q30 product, rounded half up with floor shift; operands within 34 bits.
  function automatic logic signed [33:0] qmul(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] p;
    logic signed [67:0] t;
    p = a * b;
    t = (p + 68'sd536870912) >>> Q;
    return t[33:0];
  endfunction

  // Map a half-angle phase onto the quarter-wave argument.
  function automatic logic signed [33:0] quarter_arg(input logic [31:0] p);
    logic signed [33:0] f;
    f = $signed({4'd0, p[29:0]});
    if (p[30]) f = Q30_ONE - f;
    return f;
  endfunction

endpackage

@@ rtl/core/ezvr_sine.sv @@
// Quarter-wave sine for six phases at once: fold and square, one Horner step per stage, then scale and clamp.
module ezvr_sine
  import ezvr_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [5:0][31:0]   phase,
  output logic signed [5:0][33:0] sine
);

  localparam int NS = 9;

  logic signed [33:0] f   [NS][6];
  logic signed [33:0] x2  [NS][6];
  logic signed [33:0] r   [NS][6];
  logic               neg [NS][6];
  logic signed [33:0] coef [7];

  assign coef[0] = S_C13;
  assign coef[1] = S_C11;
  assign coef[2] = S_C9;
  assign coef[3] = S_C7;
  assign coef[4] = S_C5;
  assign coef[5] = S_C3;
  assign coef[6] = S_C1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        // stage 0: fold into the first quadrant, square
        f[0][i]   <= quarter_arg(phase[i]);
        x2[0][i]  <= qmul(quarter_arg(phase[i]), quarter_arg(phase[i]));
        r[0][i]   <= coef[0];
        neg[0][i] <= phase[i][31];
        for (int s = 1; s < 7; s++) begin
          f[s][i]   <= f[s-1][i];
          x2[s][i]  <= x2[s-1][i];
          r[s][i]   <= coef[s] - qmul(r[s-1][i], x2[s-1][i]);
          neg[s][i] <= neg[s-1][i];
        end
        r[7][i]   <= qmul(r[6][i], f[6][i]);
        neg[7][i] <= neg[6][i];
        f[7][i]   <= f[6][i];
        x2[7][i]  <= x2[6][i];
        // clamp and sign
        if (r[7][i] > Q30_ONE) r[8][i] <= neg[7][i] ? -Q30_ONE : Q30_ONE;
        else if (r[7][i] < 0) r[8][i] <= '0;
        else r[8][i] <= neg[7][i] ? -r[7][i] : r[7][i];
        neg[8][i] <= neg[7][i];
        f[8][i]   <= f[7][i];
        x2[8][i]  <= x2[7][i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) sine[i] = r[NS-1][i];
  end

endmodule

@@ rtl/core/euler_zxz_vector_rotation.sv @@
// Z-X-Z Euler vector rotation. Each transaction carries a Q15.16 vector, three
// angles in fractions of a turn and a direction flag (tuser: 0 local to lab,
// 1 lab to local, which rotates by the conjugate quaternion). The block forms
// the half-angle sines and cosines with a polynomial, builds the quaternion
// Rz(phi)Rx(theta)Rz(psi), expands it to a 3x3 matrix and applies it with
// exact rounding and saturation. It is a fixed pipeline of 17 stages: one
// transaction may enter every cycle while the output is not stalled, and each
// result waits in the last stage until it is taken. All stages advance
// together on a single enable, so a stall holds every stage.
module euler_zxz_vector_rotation
  import ezvr_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int VEC_BITS   = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // vec_x, vec_y, vec_z, phi_angle, theta_angle, psi_angle (low bits up)
  input  logic [((3*VEC_BITS+3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tuser, // req_type
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // rot_x, rot_y, rot_z (low bits up)
  output logic [((3*VEC_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int SIN_LAT = 9;
  localparam int LAT     = SIN_LAT + 8;
  localparam int OW      = ((3*VEC_BITS+7)/8)*8;
  // width of the vector part above the low 24 bits, sign included
  localparam int VH_W    = (VEC_BITS > 25) ? VEC_BITS - 24 : 1;

  logic en;
  logic [LAT-1:0] vld;

  // Advance when the last stage is empty or being taken.
  assign en            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // unpack, half angle phases, cosine is sine of phase plus a quarter turn
  logic [5:0][31:0] phase;
  logic [2:0][31:0] hp;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      hp[a] = 32'(s_axis_tdata[3*VEC_BITS + a*ANGLE_BITS +: ANGLE_BITS])
              << (31 - ANGLE_BITS);
      phase[2*a]   = hp[a];
      phase[2*a+1] = hp[a] + 32'h4000_0000;
    end
  end

  logic signed [5:0][33:0] sc;
  ezvr_sine u_sine (.clk(clk), .en(en), .phase(phase), .sine(sc));

  // delay line for vector and direction alongside the sine unit
  logic signed [VEC_BITS-1:0] vd [SIN_LAT+5][3];
  logic                       td [SIN_LAT+2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        vd[0][k] <= s_axis_tdata[k*VEC_BITS +: VEC_BITS];
      td[0] <= s_axis_tuser;
      for (int s = 1; s < SIN_LAT+5; s++)
        for (int k = 0; k < 3; k++) vd[s][k] <= vd[s-1][k];
      for (int s = 1; s < SIN_LAT+2; s++) td[s] <= td[s-1];
    end
  end

  // vector widened so that the split at bit 24 holds for any width
  logic signed [63:0] vw [3];
  always_comb begin
    for (int k = 0; k < 3; k++) vw[k] = 64'(vd[SIN_LAT+4][k]);
  end

  // sc: s1 c1 s2 c2 s3 c3
  logic signed [33:0] tw, tx, ty, tz, s1, c1;
  logic signed [33:0] qw, qx, qy, qz;
  logic signed [33:0] pw [4], px [4], py [4], pz [4];
  logic signed [33:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [33:0] m [9];
  logic signed [63:0] pa [3][3], pb [3][3];
  logic signed [63:0] sa [3], sb [3];
  logic signed [VEC_BITS-1:0] res [3];

  function automatic logic signed [63:0] mul_hi(input logic signed [33:0] a,
                                                input logic signed [VH_W-1:0] b);
    logic signed [33+VH_W:0] p;
    p = a * b;
    return 64'(p);
  endfunction

  function automatic logic signed [63:0] mul_lo(input logic signed [33:0] a,
                                                input logic signed [24:0] b);
    logic signed [58:0] p;
    p = a * b;
    return 64'(p);
  endfunction

  function automatic logic signed [VEC_BITS-1:0] sat(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [63:0] ah, al, lo, r;
    logic signed [63:0] lim;
    ah  = a >>> 6;
    al  = a - (ah <<< 6);
    lo  = ((al <<< 24) + b + Q30_HALF) >>> 30;
    r   = ah + lo;
    lim = (64'sd1 <<< (VEC_BITS-1)) - 64'sd1;
    if (r > lim) r = lim;
    if (r < -lim - 64'sd1) r = -lim - 64'sd1;
    return r[VEC_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      // stage A: theta and psi combined
      tw <= qmul(sc[3], sc[5]);
      tx <= qmul(sc[2], sc[5]);
      ty <= -qmul(sc[2], sc[4]);
      tz <= qmul(sc[3], sc[4]);
      s1 <= sc[0];
      c1 <= sc[1];
      // stage B: products with phi
      pw[0] <= qmul(c1, tw); pw[1] <= qmul(s1, tz);
      px[0] <= qmul(c1, tx); px[1] <= qmul(s1, ty);
      py[0] <= qmul(c1, ty); py[1] <= qmul(s1, tx);
      pz[0] <= qmul(c1, tz); pz[1] <= qmul(s1, tw);
      // stage C: quaternion, conjugated for lab to local
      qw <= pw[0] - pw[1];
      qx <= td[SIN_LAT+1] ? px[1] - px[0] : px[0] - px[1];
      qy <= td[SIN_LAT+1] ? -(py[0] + py[1]) : py[0] + py[1];
      qz <= td[SIN_LAT+1] ? -(pz[0] + pz[1]) : pz[0] + pz[1];
      // stage D: squares and cross products
      ww <= qmul(qw, qw); xx <= qmul(qx, qx); yy <= qmul(qy, qy);
      zz <= qmul(qz, qz); xy <= qmul(qx, qy); xz <= qmul(qx, qz);
      yz <= qmul(qy, qz); wx <= qmul(qw, qx); wy <= qmul(qw, qy);
      wz <= qmul(qw, qz);
      // stage E: matrix
      m[0] <= ww + xx - yy - zz; m[1] <= (xy - wz) <<< 1; m[2] <= (xz + wy) <<< 1;
      m[3] <= (xy + wz) <<< 1; m[4] <= ww - xx + yy - zz; m[5] <= (yz - wx) <<< 1;
      m[6] <= (xz - wy) <<< 1; m[7] <= (yz + wx) <<< 1; m[8] <= ww - xx - yy + zz;
      // stage F: split products, high part of vector and low 24 bits
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          pa[i][j] <= mul_hi(m[3*i+j], vw[j][24 +: VH_W]);
          pb[i][j] <= mul_lo(m[3*i+j], {1'b0, vw[j][23:0]});
        end
      // stage G: row sums
      for (int i = 0; i < 3; i++) begin
        sa[i] <= pa[i][0] + pa[i][1] + pa[i][2];
        sb[i] <= pb[i][0] + pb[i][1] + pb[i][2];
      end
      // stage H: recombine, round, saturate
      for (int i = 0; i < 3; i++) res[i] <= sat(sa[i], sb[i]);
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 3; i++) m_axis_tdata[i*VEC_BITS +: VEC_BITS] = res[i];
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import ezvr_pkg::*;

  localparam int ANGLE_BITS = 16;
  localparam int VEC_BITS   = 32;
  localparam int IN_W  = ((3*VEC_BITS+3*ANGLE_BITS+7)/8)*8;
  localparam int OUT_W = ((3*VEC_BITS+7)/8)*8;
  localparam int PIPE_DEPTH = 17;
  localparam int N_RANDOM = 800;

  typedef struct packed {
    logic        lab_to_local;
    logic [31:0] vx, vy, vz;
    logic [15:0] phi, theta, psi;
  } rot_req_t;

  typedef struct packed {
    logic [31:0] rx, ry, rz;
  } rot_vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  euler_zxz_vector_rotation dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rot_req_t pending_reqs[$];
  rot_vec_t expected_vecs[$];
  int send_idle_pct = 26;
  int recv_idle_pct = 45;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_lab_to_local = 0;

  // ---------------------------------------------------------------------
  // Rotation arithmetic, 64-bit signed throughout.
  // ---------------------------------------------------------------------
  function automatic longint fdiv_pow2(longint v, int n);
    if (v < 0) return ~((~v) >>> n);
    return v >>> n;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return fdiv_pow2(a * b + 64'sd536870912, 30);
  endfunction

  function automatic longint quarter_sine(longint f);
    longint x2, r;
    x2 = q30_mul(f, f);
    r = 61;
    r = 3864 - q30_mul(r, x2);
    r = 172272 - q30_mul(r, x2);
    r = 5026995 - q30_mul(r, x2);
    r = 85569306 - q30_mul(r, x2);
    r = 693598668 - q30_mul(r, x2);
    r = 1686629713 - q30_mul(r, x2);
    r = q30_mul(r, f);
    if (r > 64'sd1073741824) r = 64'sd1073741824;
    if (r < 0) r = 0;
    return r;
  endfunction

  function automatic longint phase_sine(logic [31:0] p);
    longint f, s;
    f = longint'({34'd0, p[29:0]});
    if (p[30]) f = 64'sd1073741824 - f;
    s = quarter_sine(f);
    return p[31] ? -s : s;
  endfunction

  // floor((sum m*v + 2^29) / 2^30) exactly, with the products split so
  // that nothing overflows 64 bits; then clamp to the 32-bit range
  function automatic logic [31:0] apply_row(longint m0, longint m1, longint m2,
                                            longint v0, longint v1, longint v2);
    longint mm[3], vv[3];
    longint sa, sb, vh, ah, al, res;
    mm = '{m0, m1, m2};
    vv = '{v0, v1, v2};
    sa = 0;
    sb = 0;
    for (int i = 0; i < 3; i++) begin
      vh = fdiv_pow2(vv[i], 24);
      sa += mm[i] * vh;
      sb += mm[i] * (vv[i] - vh * 16777216);
    end
    ah = fdiv_pow2(sa, 6);
    al = sa - ah * 64;
    res = ah + fdiv_pow2(al * 16777216 + sb + 64'sd536870912, 30);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  function automatic rot_vec_t rotate_vector(rot_req_t r);
    logic [31:0] p1, p2, p3;
    longint s1, c1, s2, c2, s3, c3, tw, tx, ty, tz, w, x, y, z;
    longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint m[9], v0, v1, v2;
    rot_vec_t o;
    p1 = {1'b0, r.phi, 15'd0};
    p2 = {1'b0, r.theta, 15'd0};
    p3 = {1'b0, r.psi, 15'd0};
    s1 = phase_sine(p1); c1 = phase_sine(p1 + 32'h4000_0000);
    s2 = phase_sine(p2); c2 = phase_sine(p2 + 32'h4000_0000);
    s3 = phase_sine(p3); c3 = phase_sine(p3 + 32'h4000_0000);
    tw = q30_mul(c2, c3);
    tx = q30_mul(s2, c3);
    ty = -q30_mul(s2, s3);
    tz = q30_mul(c2, s3);
    w = q30_mul(c1, tw) - q30_mul(s1, tz);
    x = q30_mul(c1, tx) - q30_mul(s1, ty);
    y = q30_mul(c1, ty) + q30_mul(s1, tx);
    z = q30_mul(c1, tz) + q30_mul(s1, tw);
    // lab to local uses the conjugate quaternion
    if (r.lab_to_local) begin
      x = -x; y = -y; z = -z;
    end
    ww = q30_mul(w, w); xx = q30_mul(x, x); yy = q30_mul(y, y); zz = q30_mul(z, z);
    xy = q30_mul(x, y); xz = q30_mul(x, z); yz = q30_mul(y, z);
    wx = q30_mul(w, x); wy = q30_mul(w, y); wz = q30_mul(w, z);
    m[0] = ww + xx - yy - zz; m[1] = 2 * (xy - wz); m[2] = 2 * (xz + wy);
    m[3] = 2 * (xy + wz); m[4] = ww - xx + yy - zz; m[5] = 2 * (yz - wx);
    m[6] = 2 * (xz - wy); m[7] = 2 * (yz + wx); m[8] = ww - xx - yy + zz;
    v0 = longint'(signed'(r.vx));
    v1 = longint'(signed'(r.vy));
    v2 = longint'(signed'(r.vz));
    o.rx = apply_row(m[0], m[1], m[2], v0, v1, v2);
    o.ry = apply_row(m[3], m[4], m[5], v0, v1, v2);
    o.rz = apply_row(m[6], m[7], m[8], v0, v1, v2);
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: present the head of the queue, advance on each accepted
  // transaction, idle at random between transactions.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_vecs.push_back(rotate_vector(pending_reqs.pop_front()));
        n_sent++;
      end
      if ((!s_axis_tvalid || s_axis_tready) && pending_reqs.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        // note: head already popped above when accepted, so index 0 is next
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_reqs[0].lab_to_local;
        s_axis_tdata  <= IN_W'({pending_reqs[0].psi, pending_reqs[0].theta,
                                pending_reqs[0].phi, pending_reqs[0].vz,
                                pending_reqs[0].vy, pending_reqs[0].vx});
      end else if (!s_axis_tvalid || s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rot_vec_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.rx = m_axis_tdata[31:0];
        got.ry = m_axis_tdata[63:32];
        got.rz = m_axis_tdata[95:64];
        if (expected_vecs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_vecs.pop_front();
          if (got.rx !== want.rx) begin
            $display("%0t: rot_x expected %h actual %h", $time, want.rx, got.rx);
            errors++;
          end
          if (got.ry !== want.ry) begin
            $display("%0t: rot_y expected %h actual %h", $time, want.ry, got.ry);
            errors++;
          end
          if (got.rz !== want.rz) begin
            $display("%0t: rot_z expected %h actual %h", $time, want.rz, got.rz);
            errors++;
          end
          n_checked++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic rot_req_t random_req();
    rot_req_t r;
    r.lab_to_local = 1'($urandom_range(1));
    r.phi = 16'($urandom);
    r.theta = 16'($urandom);
    r.psi = 16'($urandom);
    // mostly moderate vectors, some full-range to reach saturation
    if ($urandom_range(3) == 0) begin
      r.vx = $urandom; r.vy = $urandom; r.vz = $urandom;
    end else begin
      r.vx = 32'(signed'(20'($urandom)));
      r.vy = 32'(signed'(20'($urandom)));
      r.vz = 32'(signed'(20'($urandom)));
    end
    return r;
  endfunction

  function automatic rot_req_t make_req(logic d, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [15:0] a,
                                        logic [15:0] b, logic [15:0] c);
    rot_req_t r;
    r = '{d, x, y, z, a, b, c};
    return r;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: identity, quarter and half turns, extreme vectors, both
    // directions, and full-scale components that drive saturation.
    pending_reqs.push_back(make_req(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                    16'h0000, 16'h0000, 16'h0000));
    pending_reqs.push_back(make_req(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                    16'h0000, 16'h0000, 16'h0000));
    pending_reqs.push_back(make_req(1'b0, 32'h0001_0000, 32'h0, 32'h0,
                                    16'h4000, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(1'b1, 32'h0001_0000, 32'h0, 32'h0,
                                    16'h4000, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(1'b0, 32'h0, 32'h0001_0000, 32'h0,
                                    16'h0, 16'h4000, 16'h0));
    pending_reqs.push_back(make_req(1'b0, 32'h0, 32'h0, 32'h0001_0000,
                                    16'h0, 16'h0, 16'h8000));
    pending_reqs.push_back(make_req(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    16'h2000, 16'h2000, 16'h2000));
    pending_reqs.push_back(make_req(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    16'h2000, 16'h2000, 16'h2000));
    pending_reqs.push_back(make_req(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(make_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(make_req(1'b0, 32'h8000_0000, 32'h0, 32'h0,
                                    16'h8000, 16'h0000, 16'h0000));
    pending_reqs.push_back(make_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    16'hC000, 16'h8000, 16'h4000));
    pending_reqs.push_back(make_req(1'b0, 32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F,
                                    16'h0001, 16'h7FFF, 16'h8001));

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 45; recv_idle_pct = 26;
      end else if (phase == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        rot_req_t rq;
        rq = random_req();
        pending_reqs.push_back(rq);
        if (rq.lab_to_local) n_lab_to_local++;
      end
      wait (pending_reqs.size() == 0);
    end

    wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_vecs.size() == 0);
    repeat (PIPE_DEPTH * 3) @(posedge clk);
    $display("Checked %0d rotation results over %0d transactions (%0d random lab to local),",
             n_checked, n_sent, n_lab_to_local);
    $display("both directions, angle and vector extremes, three stall profiles.");
    if (errors == 0 && expected_vecs.size() == 0)
      $display("** euler_zxz_vector_rotation: PASSED **");
    else
      $display("** euler_zxz_vector_rotation: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_vecs.size());
    $display("** euler_zxz_vector_rotation: FAILED **");
    $finish;
  end

endmodule
